>>> rtl/itrt_pkg.sv
// Shared constants, codes and the digit-to-ASCII function for the radix text unit.
`timescale 1ns / 1ps
package itrt_pkg;

   localparam int DEFAULT_VALUE_WIDTH = 32;

   typedef enum logic [1:0] {
      MODE_BIN = 2'd0,
      MODE_OCT = 2'd1,
      MODE_DEC = 2'd2,
      MODE_HEX = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SIGN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_MINUS   = 8'h2d;
   localparam logic [3:0] DIGIT_TEN    = 4'd10;

   function automatic logic [7:0] digit_char(input logic [3:0] digit);
      logic [3:0] above_nine;
      above_nine = digit - DIGIT_TEN;
      if (digit < DIGIT_TEN) begin
         return CHAR_ZERO + {4'b0000, digit};
      end else begin
         return CHAR_LOWER_A + {4'b0000, above_nine};
      end
   endfunction

endpackage

>>> rtl/itrt_if.sv
// Valid/ready channels for the request (value, mode) and response (character, last) beats.
`timescale 1ns / 1ps
interface itrt_req_if #(
   parameter int VALUE_WIDTH = itrt_pkg::DEFAULT_VALUE_WIDTH
);
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] value;
   logic        [1:0]             mode;

   modport source (output valid, output value, output mode, input ready);
   modport sink   (input valid, input value, input mode, output ready);
endinterface

interface itrt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

>>> rtl/signed_integer_to_radix_text_unit.sv
// Signed integer to ASCII text in radix 2, 8, 10 or 16, one character per response beat.
// Decimal first converts the magnitude to BCD by shift-and-add-3, then walks its digit slots
// (10 slots at 32 bits); other radices go straight to their digit slots (VALUE_WIDTH,
// ceil(VALUE_WIDTH/3) or ceil(VALUE_WIDTH/4)); a negative value first sends a minus sign.
// One value at a time: a new request is taken only once the block is back in idle.
// Reset clears the state machine and the response valid; the block holds nothing else.
`timescale 1ns / 1ps
module signed_integer_to_radix_text_unit #(
   parameter int VALUE_WIDTH = itrt_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   itrt_req_if.sink           req_if,
   itrt_rsp_if.source         rsp_if
);

   localparam int W      = VALUE_WIDTH;
   localparam int NDEC   = (W * 30103) / 100000 + 1;
   localparam int WW     = 4 * NDEC;
   localparam int ND_OCT = (W + 2) / 3;
   localparam int ND_HEX = (W + 3) / 4;
   localparam int SH_BIN = WW - W;
   localparam int SH_OCT = WW - 3 * ND_OCT;
   localparam int SH_HEX = WW - 4 * ND_HEX;
   localparam int CW     = $clog2(W + 1);

   itrt_pkg::state_type state_ff, state_in;
   itrt_pkg::mode_type  mode_ff, mode_in;
   logic                neg_ff, neg_in;
   logic [W-1:0]        mag_ff, mag_in;
   logic [WW-1:0]       work_ff, work_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                started_ff, started_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [7:0]          rsp_char_ff, rsp_char_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free;
   logic [W-1:0]        req_mag;
   logic [WW-1:0]       req_pad;
   logic [WW-1:0]       adj;
   logic [3:0]          digit;
   logic                show;
   logic [CW-1:0]       slots;

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = (state_ff == itrt_pkg::ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.character = rsp_char_ff;
   assign rsp_if.last   = rsp_last_ff;

   // Two's complement magnitude; the most negative value comes out as 2^(W-1) unsigned.
   assign req_mag = req_if.value[W-1] ? (~req_if.value + W'(1)) : req_if.value;
   assign req_pad = {{(WW-W){1'b0}}, req_mag};

   // Add 3 to every BCD digit of five or more before the next shift.
   always_comb begin
      for (int i = 0; i < NDEC; i++) begin
         if (work_ff[4*i +: 4] >= 4'd5) begin
            adj[4*i +: 4] = work_ff[4*i +: 4] + 4'd3;
         end else begin
            adj[4*i +: 4] = work_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      unique case (mode_ff)
         itrt_pkg::MODE_BIN: digit = {3'b000, work_ff[WW-1]};
         itrt_pkg::MODE_OCT: digit = {1'b0, work_ff[WW-1 -: 3]};
         itrt_pkg::MODE_DEC: digit = work_ff[WW-1 -: 4];
         itrt_pkg::MODE_HEX: digit = work_ff[WW-1 -: 4];
         default:            digit = work_ff[WW-1 -: 4];
      endcase
   end

   assign show = started_ff || (digit != 4'd0) || (cnt_ff == CW'(1));

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      work_in      = work_ff;
      cnt_in       = cnt_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      slots        = CW'(NDEC);

      unique case (state_ff)
         itrt_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               mode_in    = itrt_pkg::mode_type'(req_if.mode);
               neg_in     = req_if.value[W-1];
               mag_in     = req_mag;
               started_in = 1'b0;
               unique case (itrt_pkg::mode_type'(req_if.mode))
                  itrt_pkg::MODE_BIN: begin
                     work_in = req_pad << SH_BIN;
                     cnt_in  = CW'(W);
                  end
                  itrt_pkg::MODE_OCT: begin
                     work_in = req_pad << SH_OCT;
                     cnt_in  = CW'(ND_OCT);
                  end
                  itrt_pkg::MODE_HEX: begin
                     work_in = req_pad << SH_HEX;
                     cnt_in  = CW'(ND_HEX);
                  end
                  default: begin
                     work_in = '0;
                     cnt_in  = CW'(W);
                  end
               endcase
               if (itrt_pkg::mode_type'(req_if.mode) == itrt_pkg::MODE_DEC) begin
                  state_in = itrt_pkg::ST_CONV;
               end else if (req_if.value[W-1]) begin
                  state_in = itrt_pkg::ST_SIGN;
               end else begin
                  state_in = itrt_pkg::ST_EMIT;
               end
            end
         end
         itrt_pkg::ST_CONV: begin
            work_in = {adj[WW-2:0], mag_ff[W-1]};
            mag_in  = mag_ff << 1;
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == CW'(1)) begin
               cnt_in   = slots;
               state_in = neg_ff ? itrt_pkg::ST_SIGN : itrt_pkg::ST_EMIT;
            end
         end
         itrt_pkg::ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = itrt_pkg::CHAR_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = itrt_pkg::ST_EMIT;
            end
         end
         itrt_pkg::ST_EMIT: begin
            // Drop leading zeros, keep the final slot so zero still prints.
            if (out_free) begin
               if (show) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = itrt_pkg::digit_char(digit);
                  rsp_last_in  = (cnt_ff == CW'(1));
               end
               started_in = started_ff || show;
               unique case (mode_ff)
                  itrt_pkg::MODE_BIN: work_in = work_ff << 1;
                  itrt_pkg::MODE_OCT: work_in = work_ff << 3;
                  default:            work_in = work_ff << 4;
               endcase
               cnt_in = cnt_ff - CW'(1);
               if (cnt_ff == CW'(1)) begin
                  state_in = itrt_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = itrt_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itrt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      neg_ff      <= neg_in;
      mag_ff      <= mag_in;
      work_ff     <= work_in;
      cnt_ff      <= cnt_in;
      started_ff  <= started_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule
